### src/evp_pkg.sv
// Shared types and constants of the elevation/visibility pixel writer.
// Used by the channel interfaces, the divider, the byte emitter and the top level.
// No dependencies.
`default_nettype none

package evp_pkg;

   // Field widths
   localparam int ELEV_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int ROW_W   = 13;
   localparam int CSR_W   = 16;
   localparam int QUO_W   = 7;                // quotient never exceeds 123
   localparam int NUM_W   = ELEV_W + QUO_W;   // (h - low) * 123 fits here

   typedef logic signed [ELEV_W-1:0] elev_type;
   typedef logic [BYTE_W-1:0]        pix_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_RANGE_LOW      = 3'd0,
      REG_RANGE_HIGH     = 3'd1,
      REG_MISSING_CODE   = 3'd2,
      REG_VIEWPOINT_CODE = 3'd3,
      REG_ROW_PIXELS     = 3'd4
   } csr_index_type;

   // Register reset values
   localparam elev_type         RANGE_LOW_RST      = 16'sh0000;
   localparam elev_type         RANGE_HIGH_RST     = 16'sh0000;
   localparam elev_type         MISSING_CODE_RST   = 16'sh8000;
   localparam elev_type         VIEWPOINT_CODE_RST = 16'sh8001;
   localparam logic [ROW_W-1:0] ROW_PIXELS_RST     = 13'd1;

   // Palette codes
   localparam pix_type CODE_MISSING   = 8'd255;
   localparam pix_type CODE_VIEWPOINT = 8'd254;
   localparam pix_type CODE_SEA       = 8'd0;
   localparam pix_type CODE_PAD       = 8'd0;
   localparam pix_type FLAT_SEEN      = 8'd191;
   localparam pix_type FLAT_HIDDEN    = 8'd63;
   localparam pix_type BASE_SEEN      = 8'd130;
   localparam pix_type BASE_HIDDEN    = 8'd2;
   localparam pix_type SHADE_STEPS    = 8'd123;

   // Pixel word handed from the mapper to the emitter
   typedef struct packed {
      logic    load;
      pix_type pixel;
   } pix_word_type;

   // Divider status back to the mapper
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

### src/evp_channels.sv
// Valid/ready channel interfaces of the pixel writer: sample words in, byte words out.
// Depends on evp_pkg.
`default_nettype none

interface evp_req_if import evp_pkg::*; ();
   logic     valid;
   logic     ready;
   elev_type elevation;
   logic     seen;
   logic     viewpoint_mark;

   modport source (output valid, elevation, seen, viewpoint_mark, input ready);
   modport sink   (input valid, elevation, seen, viewpoint_mark, output ready);
endinterface

interface evp_rsp_if import evp_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type pixel_byte;
   logic    is_padding;
   logic    last;

   modport source (output valid, pixel_byte, is_padding, last, input ready);
   modport sink   (input valid, pixel_byte, is_padding, last, output ready);
endinterface

`default_nettype wire

### src/evp_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, QUO_W quotient bits per divide.
// The dividend must be below divisor << QUO_W. Depends on evp_pkg.
`default_nettype none

module evp_divider import evp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  dividend,
   input  wire logic [ELEV_W-1:0] divisor,
   output div_stat_type           status
);

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [CNT_W-1:0]    step_ff,  step_in;
   logic [ELEV_W-1:0]   rem_ff,   rem_in;
   logic [QUO_W-1:0]    shift_ff, shift_in;
   logic [QUO_W-1:0]    quo_ff,   quo_in;
   logic [ELEV_W-1:0]   den_ff,   den_in;
   logic [ELEV_W:0]     trial;
   logic                fits;

   // Shift the next dividend bit into the partial remainder and try a subtract
   assign trial = {rem_ff, shift_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = dividend[NUM_W-1:QUO_W];
         shift_in = dividend[QUO_W-1:0];
         quo_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? ELEV_W'(trial - {1'b0, den_ff}) : trial[ELEV_W-1:0];
         shift_in = {shift_ff[QUO_W-2:0], 1'b0};
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         step_in  = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

`default_nettype wire

### src/evp_emitter.sv
// Output stage: holds the byte word for the sink, counts columns and appends row padding.
// Depends on evp_pkg and evp_rsp_if.
`default_nettype none

module evp_emitter import evp_pkg::*; #(
   parameter int MAX_ROW_PIXELS = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pix_word_type     word,
   input  wire logic [ROW_W-1:0] row_pixels,
   output logic                  busy,
   evp_rsp_if.source             rsp_chan
);

   localparam int CNT_W = $clog2(MAX_ROW_PIXELS);
   localparam int LEN_W = (CNT_W + 1 > ROW_W) ? CNT_W + 1 : ROW_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ROW_PIXELS);

   logic             valid_ff,    valid_in;
   pix_type          byte_ff,     byte_in;
   logic             padding_ff,  padding_in;
   logic             last_ff,     last_in;
   logic [1:0]       pad_left_ff, pad_left_in;
   logic [CNT_W-1:0] col_ff,      col_in;

   logic [LEN_W-1:0] req_len;
   logic [LEN_W-1:0] row_len;
   logic [LEN_W-1:0] col_next;
   logic             row_end;
   logic [1:0]       pad_count;

   // Effective row length, clamped to 1..MAX_ROW_PIXELS
   always_comb begin
      req_len = LEN_W'(row_pixels);
      if (req_len == '0) begin
         row_len = LEN_W'(1);
      end else if (req_len > MAX_LEN) begin
         row_len = MAX_LEN;
      end else begin
         row_len = req_len;
      end
   end

   assign col_next  = LEN_W'(col_ff) + LEN_W'(1);
   assign row_end   = col_next >= row_len;
   assign pad_count = 2'(-row_len[1:0]);

   // Load a pixel, then step through padding words as the sink takes them
   always_comb begin
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      padding_in  = padding_ff;
      last_in     = last_ff;
      pad_left_in = pad_left_ff;
      col_in      = col_ff;
      if (word.load) begin
         valid_in    = 1'b1;
         byte_in     = word.pixel;
         padding_in  = 1'b0;
         last_in     = !row_end || (pad_count == 2'd0);
         pad_left_in = row_end ? pad_count : 2'd0;
         col_in      = row_end ? '0 : col_next[CNT_W-1:0];
      end else if (valid_ff && rsp_chan.ready) begin
         if (pad_left_ff != 2'd0) begin
            byte_in     = CODE_PAD;
            padding_in  = 1'b1;
            last_in     = pad_left_ff == 2'd1;
            pad_left_in = pad_left_ff - 2'd1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pad_left_ff <= 2'd0;
         col_ff      <= '0;
      end else begin
         valid_ff    <= valid_in;
         pad_left_ff <= pad_left_in;
         col_ff      <= col_in;
      end
      byte_ff    <= byte_in;
      padding_ff <= padding_in;
      last_ff    <= last_in;
   end

   assign busy                = valid_ff;
   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.pixel_byte = byte_ff;
   assign rsp_chan.is_padding = padding_ff;
   assign rsp_chan.last       = last_ff;

endmodule

`default_nettype wire

### src/elevation_visibility_pixel_writer.sv
// Elevation/visibility pixel writer: one sample word in, 1 to 4 byte words out.
// Path: a scaled shade goes through S_CALC, S_START and S_DIV (7-step bit-serial divider)
// to S_OUT; a coded or flat/inverted-range pixel goes from S_CALC straight to S_OUT.
// One sample at a time, taken again once the pixel word is with the emitter; padding words
// follow it at one per cycle while the sink is ready, and hold off the next pixel word.
// Reset: synchronous, active high; clears registers to defaults and the column count.
`default_nettype none

module elevation_visibility_pixel_writer import evp_pkg::*; #(
   parameter int MAX_ROW_PIXELS = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   evp_req_if.sink               req_chan,
   evp_rsp_if.source             rsp_chan,
   input  wire logic             csr_write_en,
   input  wire csr_index_type    csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_START,
      S_DIV,
      S_OUT
   } state_type;

   state_type        state_ff,  state_in;
   elev_type         elev_ff,   elev_in;
   logic             seen_ff,   seen_in;
   logic             mark_ff,   mark_in;
   pix_type          pixel_ff,  pixel_in;
   logic [NUM_W-1:0] num_ff,    num_in;
   logic             ready_ff,  ready_in;

   elev_type         range_low_ff;
   elev_type         range_high_ff;
   elev_type         missing_ff;
   elev_type         viewpoint_ff;
   logic [ROW_W-1:0] row_pixels_ff;

   logic signed [ELEV_W:0] span;
   elev_type               clamp_lo;
   elev_type               clamped;
   logic signed [ELEV_W:0] offset;
   pix_type                base;
   logic                   div_start;
   div_stat_type           div_stat;
   pix_word_type           emit_word;
   logic                   emit_busy;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RST;
         range_high_ff <= RANGE_HIGH_RST;
         missing_ff    <= MISSING_CODE_RST;
         viewpoint_ff  <= VIEWPOINT_CODE_RST;
         row_pixels_ff <= ROW_PIXELS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_RANGE_LOW:      range_low_ff  <= csr_wdata;
            REG_RANGE_HIGH:     range_high_ff <= csr_wdata;
            REG_MISSING_CODE:   missing_ff    <= csr_wdata;
            REG_VIEWPOINT_CODE: viewpoint_ff  <= csr_wdata;
            REG_ROW_PIXELS:     row_pixels_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Span of the shade range and clamped offset of the sample within it
   assign span     = {range_high_ff[ELEV_W-1], range_high_ff}
                     - {range_low_ff[ELEV_W-1], range_low_ff};
   assign clamp_lo = (elev_ff < range_low_ff) ? range_low_ff : elev_ff;
   assign clamped  = (clamp_lo > range_high_ff) ? range_high_ff : clamp_lo;
   assign offset   = {clamped[ELEV_W-1], clamped} - {range_low_ff[ELEV_W-1], range_low_ff};
   assign base     = seen_ff ? BASE_SEEN : BASE_HIDDEN;

   // Sequence one sample: classify, scale, divide, hand to the emitter
   always_comb begin
      state_in = state_ff;
      elev_in  = elev_ff;
      seen_in  = seen_ff;
      mark_in  = mark_ff;
      pixel_in = pixel_ff;
      num_in   = num_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               elev_in  = req_chan.elevation;
               seen_in  = req_chan.seen;
               mark_in  = req_chan.viewpoint_mark;
               ready_in = 1'b0;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = S_OUT;
            num_in   = NUM_W'(offset[ELEV_W-1:0]) * NUM_W'(SHADE_STEPS);
            if (mark_ff) begin
               pixel_in = CODE_VIEWPOINT;
            end else if (elev_ff == missing_ff) begin
               pixel_in = CODE_MISSING;
            end else if (elev_ff == viewpoint_ff) begin
               pixel_in = CODE_VIEWPOINT;
            end else if (elev_ff == '0) begin
               pixel_in = CODE_SEA;
            end else if (elev_ff < 0) begin
               pixel_in = CODE_MISSING;
            end else if (span == '0) begin
               pixel_in = seen_ff ? FLAT_SEEN : FLAT_HIDDEN;
            end else if (span < 0) begin
               pixel_in = base + SHADE_STEPS;
            end else begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               pixel_in = base + BYTE_W'(div_stat.quotient);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!emit_busy) begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
      elev_ff  <= elev_in;
      seen_ff  <= seen_in;
      mark_ff  <= mark_in;
      pixel_ff <= pixel_in;
      num_ff   <= num_in;
   end

   assign req_chan.ready = ready_ff;
   assign div_start      = state_ff == S_START;

   evp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (span[ELEV_W-1:0]),
      .status   (div_stat)
   );

   assign emit_word.load  = (state_ff == S_OUT) && !emit_busy;
   assign emit_word.pixel = pixel_ff;

   evp_emitter #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .word       (emit_word),
      .row_pixels (row_pixels_ff),
      .busy       (emit_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

### src/evp_checker.sv
// Port-level checks of the pixel writer, attached to the top level by bind.
// Depends on evp_pkg and the top level elevation_visibility_pixel_writer.
`default_nettype none

module evp_checker import evp_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire pix_type rsp_pixel_byte,
   input wire logic    rsp_is_padding,
   input wire logic    rsp_last
);

   // A stalled byte word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pixel_byte) && $stable(rsp_is_padding) && $stable(rsp_last))
      else $error("byte word changed while stalled");

   // Leave reset idle: ready for a sample, no byte word pending
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // One sample at a time: ready drops after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken back to back");

   // Padding words carry zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_padding |-> rsp_pixel_byte == CODE_PAD)
      else $error("nonzero padding byte");

   // A word that is not last is followed at once by a padding word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_is_padding)
      else $error("padding word missing after non-last word");

endmodule

bind elevation_visibility_pixel_writer evp_checker u_evp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pixel_byte (rsp_chan.pixel_byte),
   .rsp_is_padding (rsp_chan.is_padding),
   .rsp_last       (rsp_chan.last)
);

`default_nettype wire
